// File: sv/rsp_pkg.sv
// Package for the retention slot policy unit: sizes, codes and beat types.
// Used by every module of the block but rsp_ram; depends on nothing.
package rsp_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int STAMP_W = 48;
    localparam int SEQ_W   = 32;
    localparam int PRIO_W  = 8;
    localparam int PCT_W   = 7;
    localparam int PERCENT = 100;
    localparam int REC_W   = PRIO_W + SEQ_W + STAMP_W;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_MARK  = 2'd1,
        OP_PRUNE = 2'd2,
        OP_PEEK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_REJECTED  = 2'd2,
        STAT_INVALID   = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        CFG_BEST_EFFORT = 2'd0,
        CFG_GUARANTEED  = 2'd1,
        CFG_WARN_PCT    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [PRIO_W-1:0]  priority_req;
        logic [STAMP_W-1:0] time_ms;
        logic [SEQ_W-1:0]   seq_in;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         slot_out;
        logic [SEQ_W-1:0]   seq_out;
        logic [PRIO_W-1:0]  prio_out;
        logic [STAMP_W-1:0] stamp_out;
        logic               lost_unuploaded;
        logic [8:0]         pruned_count;
        logic [8:0]         used_count;
        logic [8:0]         unsent_count;
        logic               fill_alert;
    } out_t;

    typedef struct packed {
        in_t  item;
        logic bad;
    } cmd_t;

endpackage

// File: sv/retention_slot_policy_unit.sv
// Retention slot policy unit: top level joining the front queue and the back scanner.
// Depends on rsp_pkg, rsp_front, rsp_back.
//
// Input beats arrive on s_valid/s_ready/s_data and carry one command each:
// store, mark uploaded, prune or peek. Each command yields exactly one result
// beat on m_valid/m_ready/m_data, in order. The front takes up to two beats
// into a queue while the back is busy. The back reads every slot record from
// its slot RAM once, one slot per cycle; a mark with a zero sequence skips
// the scan. The back takes no new command before it has issued the result of
// the last one, so the single read port of the slot RAM sets the throughput.
// Registers are written through cfg_we, cfg_index, cfg_data only while the
// unit is idle; the user is bound to this, the unit does not enforce it. A
// synchronous low aresetn empties the index and the queue, restores the register
// defaults and sets the next sequence to one; the slot RAM needs no clearing
// because its used marks live in flip-flops. When the receiver holds m_ready low,
// the result waits in the output register and the back stalls before writing its
// next result; the front keeps accepting until the queue is full.
module retention_slot_policy_unit
    import rsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [STAMP_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data
);

    logic q_valid;
    logic q_pop;
    cmd_t q_data;

    rsp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    rsp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: sv/rsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/rsp_front.sv
// Front part: accepts input beats, flags malformed marks, and queues commands.
// Depends on rsp_pkg.
module rsp_front
    import rsp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic q_valid,
    input  logic q_pop,
    output cmd_t q_data
);

    cmd_t       buf_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_pop;

    always_comb begin
        cmd_in.item = s_data;
        cmd_in.bad  = (op_t'(s_data.op) == OP_MARK) && (s_data.seq_in == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                buf_reg[wr_ptr_reg] <= cmd_in;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: sv/rsp_back.sv
// Back part: scans the slot index once per well-formed command and applies the result.
// Holds configuration, slot marks and counters. Depends on rsp_pkg, rsp_ram.
module rsp_back
    import rsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STAMP_W-1:0] cfg_data,
    input  logic              q_valid,
    output logic              q_pop,
    input  cmd_t              q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [STAMP_W-1:0]  be_ret_reg;
    logic [STAMP_W-1:0]  gr_ret_reg;
    logic [PCT_W-1:0]    warn_pct_reg;
    logic [SLOTS-1:0]    used_vec_reg;
    logic [SLOTS-1:0]    upl_vec_reg;
    logic [SEQ_W-1:0]    next_seq_reg;
    logic [CNT_W-1:0]    used_total_reg;
    logic [CNT_W-1:0]    unup_total_reg;
    logic [CNT_W-1:0]    pruned_reg;
    logic [CNT_W-1:0]    issue_idx_reg;
    logic                chk_v_reg;
    logic [SLOT_W-1:0]   chk_idx_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;

    logic                f_f_reg;
    logic [SLOT_W-1:0]   f_slot_reg;
    logic                a_f_reg;
    logic [SLOT_W-1:0]   a_slot_reg;
    logic [SEQ_W-1:0]    a_seq_reg;
    logic [PRIO_W-1:0]   a_prio_reg;
    logic [STAMP_W-1:0]  a_stamp_reg;
    logic                b_f_reg;
    logic [SLOT_W-1:0]   b_slot_reg;
    logic [SEQ_W-1:0]    b_seq_reg;
    logic                c_f_reg;
    logic [SLOT_W-1:0]   c_slot_reg;
    logic [SEQ_W-1:0]    c_seq_reg;
    logic [PRIO_W-1:0]   c_prio_reg;

    logic                ram_we;
    logic [REC_W-1:0]    ram_wdata;
    logic [REC_W-1:0]    ram_rdata;
    logic [PRIO_W-1:0]   d_prio;
    logic [SEQ_W-1:0]    d_seq;
    logic [STAMP_W-1:0]  d_stamp;
    logic                d_used;
    logic                d_upl;
    logic [STAMP_W-1:0]  now;
    logic [STAMP_W-1:0]  age;
    logic                stamp_ok;
    logic                aged_be;
    logic                aged_gr;
    logic                issuing;
    logic                out_free;
    op_t                 op;

    logic                sel_f;
    logic [SLOT_W-1:0]   sel_slot;
    logic                sel_fresh;
    logic [CNT_W-1:0]    used_next;
    logic [CNT_W-1:0]    unup_next;
    logic [CNT_W+PCT_W-1:0] fill_prod;
    out_t                res_next;

    rsp_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sel_slot),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign op        = op_t'(cmd_reg.item.op);
    assign now       = cmd_reg.item.time_ms;
    assign {d_prio, d_seq, d_stamp} = ram_rdata;
    assign d_used    = used_vec_reg[chk_idx_reg];
    assign d_upl     = upl_vec_reg[chk_idx_reg];
    assign age       = now - d_stamp;
    assign stamp_ok  = d_used && (d_stamp != '0) && (now >= d_stamp);
    assign aged_be   = stamp_ok && (age >= be_ret_reg);
    assign aged_gr   = stamp_ok && (age >= gr_ret_reg);
    assign issuing   = (issue_idx_reg < CNT_W'(SLOTS));
    assign out_free  = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign ram_wdata = {cmd_reg.item.priority_req, next_seq_reg, now};
    assign ram_we    = (state_reg == ST_DONE) && out_free && !cmd_reg.bad
                       && (op == OP_STORE) && sel_f;

    always_comb begin
        sel_f     = 1'b1;
        sel_fresh = 1'b0;
        sel_slot  = f_slot_reg;
        priority if ((used_total_reg < CNT_W'(SLOTS)) && f_f_reg) begin
            sel_fresh = 1'b1;
        end else if (a_f_reg) begin
            sel_slot = a_slot_reg;
        end else if (b_f_reg) begin
            sel_slot = b_slot_reg;
        end else if (c_f_reg) begin
            sel_slot = c_slot_reg;
        end else begin
            sel_f = 1'b0;
        end
    end

    always_comb begin
        res_next  = '0;
        used_next = used_total_reg;
        unup_next = unup_total_reg;
        if (cmd_reg.bad) begin
            res_next.status = STAT_INVALID;
        end else begin
            unique case (op)
                OP_STORE: begin
                    if (!sel_f) begin
                        res_next.status = STAT_REJECTED;
                    end else begin
                        res_next.slot_out = 8'(sel_slot);
                        res_next.seq_out  = next_seq_reg;
                        res_next.lost_unuploaded = !sel_fresh && !upl_vec_reg[sel_slot];
                        used_next = used_total_reg + CNT_W'(sel_fresh);
                        unup_next = unup_total_reg
                                    + CNT_W'(sel_fresh || upl_vec_reg[sel_slot]);
                    end
                end
                OP_MARK: begin
                    if (!a_f_reg) begin
                        res_next.status = STAT_NOT_FOUND;
                    end else begin
                        res_next.slot_out = 8'(a_slot_reg);
                        unup_next = unup_total_reg - CNT_W'(!upl_vec_reg[a_slot_reg]);
                    end
                end
                OP_PRUNE: begin
                    res_next.pruned_count = 9'(pruned_reg);
                end
                OP_PEEK: begin
                    if (!a_f_reg) begin
                        res_next.status = STAT_NOT_FOUND;
                    end else begin
                        res_next.slot_out  = 8'(a_slot_reg);
                        res_next.seq_out   = a_seq_reg;
                        res_next.prio_out  = a_prio_reg;
                        res_next.stamp_out = a_stamp_reg;
                    end
                end
                default: begin
                    res_next.status = STAT_INVALID;
                end
            endcase
        end
        fill_prod = (CNT_W+PCT_W)'(used_next) * (CNT_W+PCT_W)'(PERCENT);
        res_next.used_count   = 9'(used_next);
        res_next.unsent_count = 9'(unup_next);
        res_next.fill_alert   =
            ((fill_prod / (CNT_W+PCT_W)'(SLOTS)) >= (CNT_W+PCT_W)'(warn_pct_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            be_ret_reg     <= STAMP_W'(604800000);
            gr_ret_reg     <= STAMP_W'(86400000);
            warn_pct_reg   <= PCT_W'(80);
            used_vec_reg   <= '0;
            upl_vec_reg    <= '0;
            next_seq_reg   <= SEQ_W'(1);
            used_total_reg <= '0;
            unup_total_reg <= '0;
            pruned_reg     <= '0;
            issue_idx_reg  <= '0;
            chk_v_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            f_f_reg        <= 1'b0;
            a_f_reg        <= 1'b0;
            b_f_reg        <= 1'b0;
            c_f_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BEST_EFFORT: be_ret_reg   <= cfg_data;
                    CFG_GUARANTEED:  gr_ret_reg   <= cfg_data;
                    CFG_WARN_PCT:    warn_pct_reg <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg       <= q_data;
                        issue_idx_reg <= '0;
                        chk_v_reg     <= 1'b0;
                        pruned_reg    <= '0;
                        f_f_reg       <= 1'b0;
                        a_f_reg       <= 1'b0;
                        b_f_reg       <= 1'b0;
                        c_f_reg       <= 1'b0;
                        state_reg     <= q_data.bad ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    chk_v_reg   <= issuing;
                    chk_idx_reg <= issue_idx_reg[SLOT_W-1:0];
                    if (issuing) begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    end
                    if (chk_v_reg) begin
                        unique case (op)
                            OP_STORE: begin
                                if (!d_used && !f_f_reg) begin
                                    f_f_reg    <= 1'b1;
                                    f_slot_reg <= chk_idx_reg;
                                end
                                if (d_upl && aged_be && (!a_f_reg || d_seq < a_seq_reg)) begin
                                    a_f_reg    <= 1'b1;
                                    a_slot_reg <= chk_idx_reg;
                                    a_seq_reg  <= d_seq;
                                end
                                if (d_upl && aged_gr && (!b_f_reg || d_seq < b_seq_reg)) begin
                                    b_f_reg    <= 1'b1;
                                    b_slot_reg <= chk_idx_reg;
                                    b_seq_reg  <= d_seq;
                                end
                                if (aged_gr && (d_prio < cmd_reg.item.priority_req)
                                    && (!c_f_reg || d_prio < c_prio_reg
                                        || (d_prio == c_prio_reg && d_seq < c_seq_reg))) begin
                                    c_f_reg    <= 1'b1;
                                    c_slot_reg <= chk_idx_reg;
                                    c_seq_reg  <= d_seq;
                                    c_prio_reg <= d_prio;
                                end
                            end
                            OP_MARK: begin
                                if (d_used && !a_f_reg && d_seq == cmd_reg.item.seq_in) begin
                                    a_f_reg    <= 1'b1;
                                    a_slot_reg <= chk_idx_reg;
                                end
                            end
                            OP_PRUNE: begin
                                if (d_upl && aged_be) begin
                                    used_vec_reg[chk_idx_reg] <= 1'b0;
                                    upl_vec_reg[chk_idx_reg]  <= 1'b0;
                                    used_total_reg <= used_total_reg - CNT_W'(1);
                                    pruned_reg     <= pruned_reg + CNT_W'(1);
                                end
                            end
                            OP_PEEK: begin
                                if (d_used && !d_upl && (!a_f_reg || d_seq < a_seq_reg)) begin
                                    a_f_reg     <= 1'b1;
                                    a_slot_reg  <= chk_idx_reg;
                                    a_seq_reg   <= d_seq;
                                    a_prio_reg  <= d_prio;
                                    a_stamp_reg <= d_stamp;
                                end
                            end
                            default: ;
                        endcase
                        if (chk_idx_reg == SLOT_W'(SLOTS - 1)) begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_data_reg     <= res_next;
                        used_total_reg <= used_next;
                        unup_total_reg <= unup_next;
                        if (!cmd_reg.bad && op == OP_STORE && sel_f) begin
                            used_vec_reg[sel_slot] <= 1'b1;
                            upl_vec_reg[sel_slot]  <= 1'b0;
                            next_seq_reg <= (next_seq_reg == '1) ? SEQ_W'(1)
                                                                 : next_seq_reg + SEQ_W'(1);
                        end
                        if (!cmd_reg.bad && op == OP_MARK && a_f_reg) begin
                            upl_vec_reg[a_slot_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/rsp_checker.sv
// Port-level checker for the retention slot policy unit, bound to the top level.
// Depends on rsp_pkg and retention_slot_policy_unit.
module rsp_checker
    import rsp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input out_t               m_data
);

    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result beat shown right after reset.");

    a_unup_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.unsent_count <= m_data.used_count)
        else $error("More unuploaded records than used slots.");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("Input not ready right after reset.");

endmodule

bind retention_slot_policy_unit rsp_checker u_rsp_checker (.*);
